[hw/rtl/gcm_pkg.sv]
package gcm_pkg;

  localparam int ValueWidth = 32;
  localparam int NumBins    = 18;
  localparam int BinWidth   = 5;
  localparam int ChanWidth  = 8;
  localparam int NumChans   = 3;

  localparam int Div1Steps  = BinWidth;
  localparam int Div2Steps  = ChanWidth;
  localparam int Div1Width  = ValueWidth + 5;
  localparam int Div2Width  = ValueWidth + 9;
  localparam int NumWidth   = ValueWidth + 1;

  localparam int StS1       = 0;
  localparam int StS2       = 1;
  localparam int StDiv1     = 2;
  localparam int StNum      = StDiv1 + Div1Steps;
  localparam int StMul      = StNum + 1;
  localparam int StDiv2     = StMul + 1;
  localparam int StOut      = StDiv2 + Div2Steps;
  localparam int NumStages  = StOut + 1;

  localparam logic [31:0] AlphaOpaque = 32'hff00_0000;

  localparam logic RegRangeMin = 1'b0;
  localparam logic RegRangeMax = 1'b1;

  typedef logic [1:0] half_t;
  typedef half_t [0:NumChans-1] rgb_half_t;

  localparam rgb_half_t CmapHalf [NumBins+1] = '{
    '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd2},
    '{2'd1, 2'd2, 2'd1}, '{2'd2, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd2, 2'd0}, '{2'd1, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd2}, '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd0, 2'd0}
  };

  typedef struct packed {
    logic [Div1Width-1:0]  rem;
    logic [BinWidth-1:0]   q;
    logic [ValueWidth-1:0] span;
    logic                  blk;
  } div1_t;

  typedef struct packed {
    logic [NumChans-1:0][Div2Width-1:0] rem;
    logic [NumChans-1:0][ChanWidth-1:0] q;
    logic [ValueWidth-1:0]              span;
    logic                               blk;
  } div2_t;

  function automatic logic [NumWidth-1:0] scale_half(half_t h, logic [ValueWidth-1:0] v);
    logic [NumWidth-1:0] res;
    case (h)
      2'd1:    res = {1'b0, v};
      2'd2:    res = {v, 1'b0};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/gradient_color_map.sv]
// Gradient colour map: one unsigned fixed-point sample in, one opaque ARGB word out.
// Input channel: in_valid_i / in_stall_o with sample_i; a transaction completes on a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with argb_o, same rule.
// Configuration: cfg_we_i writes cfg_data_i into range_min (index 0) or range_max
// (index 1); write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_stall_i is low. The pipeline depth is
// set mostly by two pipelined restoring dividers: five stages find the bin, eight more
// find the three 8-bit colour channels in parallel.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up and input is accepted while a result waits in the output register.
// When out_stall_i is held with a full pipeline, in_stall_o rises and every stage
// holds its contents; nothing is dropped or duplicated.
// Reset clears all stage valid bits and sets range_min to 0 and range_max to all ones.
// An empty range (max not above min) or a sample at or above range_max gives
// 0xff000000.
module gradient_color_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gcm_pkg::ValueWidth-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  argb_o
);
  import gcm_pkg::*;

  logic [ValueWidth-1:0] range_min_q, range_max_q;
  logic [NumStages-1:0]  valid_q, valid_d, stage_ready;

  logic [ValueWidth-1:0] s1_off_q, s1_span_q, s1_off_d, s1_span_d;
  logic                  s1_empty_q, s1_empty_d;

  logic [Div1Width-1:0]  s2_dvd_q, s2_dvd_d;
  logic [ValueWidth-1:0] s2_span_q;
  logic                  s2_blk_q, s2_blk_d;

  div1_t                 div1_cur [Div1Steps];
  div1_t                 div1_d   [Div1Steps];
  div1_t                 div1_q   [Div1Steps];
  logic [Div1Width-1:0]  div1_sh  [Div1Steps];

  logic [BinWidth-1:0]   bin;
  logic [ValueWidth-1:0] bin_rem, bin_rest;
  rgb_half_t             row0, row1;
  logic [NumChans-1:0][NumWidth-1:0] num_d, num_q;
  logic [ValueWidth-1:0] num_span_q;
  logic                  num_blk_q;

  logic [NumChans-1:0][Div2Width-1:0] mul_dvd_d, mul_dvd_q;
  logic [ValueWidth-1:0] mul_span_q;
  logic                  mul_blk_q;

  div2_t                 div2_cur [Div2Steps];
  div2_t                 div2_d   [Div2Steps];
  div2_t                 div2_q   [Div2Steps];
  logic [Div2Width-1:0]  div2_sh  [Div2Steps];

  logic [31:0]           argb_d, argb_q;

  // Stage handshake
  always_comb begin
    stage_ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
    valid_d = valid_q;
    if (stage_ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stage_ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  assign in_stall_o  = !stage_ready[StS1];
  assign out_valid_o = valid_q[StOut];
  assign argb_o      = argb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      range_min_q <= '0;
      range_max_q <= '1;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegRangeMin: range_min_q <= cfg_data_i[ValueWidth-1:0];
          RegRangeMax: range_max_q <= cfg_data_i[ValueWidth-1:0];
          default:     range_max_q <= range_max_q;
        endcase
      end
    end
  end

  // Offset and span
  always_comb begin
    s1_span_d  = range_max_q - range_min_q;
    s1_empty_d = range_max_q <= range_min_q;
    s1_off_d   = (sample_i > range_min_q) ? sample_i - range_min_q : '0;
  end

  // Scale by bin count
  always_comb begin
    s2_dvd_d = {s1_off_q, 4'b0000} + {4'b0000, s1_off_q, 1'b0};
    s2_blk_d = s1_empty_q || (s1_off_q >= s1_span_q);
  end

  // Bin search, one quotient bit a stage
  always_comb begin
    div1_cur[0] = div1_t'{rem: s2_dvd_q, q: '0, span: s2_span_q, blk: s2_blk_q};
    for (int j = 1; j < Div1Steps; j++) begin
      div1_cur[j] = div1_q[j-1];
    end
    for (int j = 0; j < Div1Steps; j++) begin
      div1_sh[j] = Div1Width'(div1_cur[j].span) << (Div1Steps - 1 - j);
      div1_d[j]  = div1_cur[j];
      if (div1_cur[j].rem >= div1_sh[j]) begin
        div1_d[j].rem = div1_cur[j].rem - div1_sh[j];
        div1_d[j].q   = div1_cur[j].q | (BinWidth'(1) << (Div1Steps - 1 - j));
      end
    end
  end

  // Table lookup and blend numerator
  always_comb begin
    bin      = div1_q[Div1Steps-1].q;
    bin_rem  = div1_q[Div1Steps-1].rem[ValueWidth-1:0];
    bin_rest = div1_q[Div1Steps-1].span - bin_rem;
    row0     = CmapHalf[bin];
    row1     = CmapHalf[bin + 5'd1];
    for (int c = 0; c < NumChans; c++) begin
      num_d[c] = scale_half(row0[c], bin_rest) + scale_half(row1[c], bin_rem);
    end
  end

  // Times 255
  always_comb begin
    for (int c = 0; c < NumChans; c++) begin
      mul_dvd_d[c] = {num_q[c], 8'h00} - {8'h00, num_q[c]};
    end
  end

  // Channel division by twice the span
  always_comb begin
    div2_cur[0] = div2_t'{rem: mul_dvd_q, q: '0, span: mul_span_q, blk: mul_blk_q};
    for (int j = 1; j < Div2Steps; j++) begin
      div2_cur[j] = div2_q[j-1];
    end
    for (int j = 0; j < Div2Steps; j++) begin
      div2_sh[j] = Div2Width'(div2_cur[j].span) << (Div2Steps - j);
      div2_d[j]  = div2_cur[j];
      for (int c = 0; c < NumChans; c++) begin
        if (div2_cur[j].rem[c] >= div2_sh[j]) begin
          div2_d[j].rem[c] = div2_cur[j].rem[c] - div2_sh[j];
          div2_d[j].q[c]   = div2_cur[j].q[c] | (ChanWidth'(1) << (Div2Steps - 1 - j));
        end
      end
    end
  end

  // Pack
  always_comb begin
    if (div2_q[Div2Steps-1].blk) begin
      argb_d = AlphaOpaque;
    end else begin
      argb_d = AlphaOpaque | {8'h00, div2_q[Div2Steps-1].q[0], div2_q[Div2Steps-1].q[1],
                              div2_q[Div2Steps-1].q[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[StS1]) begin
      s1_off_q   <= s1_off_d;
      s1_span_q  <= s1_span_d;
      s1_empty_q <= s1_empty_d;
    end
    if (stage_ready[StS2]) begin
      s2_dvd_q  <= s2_dvd_d;
      s2_span_q <= s1_span_q;
      s2_blk_q  <= s2_blk_d;
    end
    for (int j = 0; j < Div1Steps; j++) begin
      if (stage_ready[StDiv1+j]) begin
        div1_q[j] <= div1_d[j];
      end
    end
    if (stage_ready[StNum]) begin
      num_q      <= num_d;
      num_span_q <= div1_q[Div1Steps-1].span;
      num_blk_q  <= div1_q[Div1Steps-1].blk;
    end
    if (stage_ready[StMul]) begin
      mul_dvd_q  <= mul_dvd_d;
      mul_span_q <= num_span_q;
      mul_blk_q  <= num_blk_q;
    end
    for (int j = 0; j < Div2Steps; j++) begin
      if (stage_ready[StDiv2+j]) begin
        div2_q[j] <= div2_d[j];
      end
    end
    if (stage_ready[StOut]) begin
      argb_q <= argb_d;
    end
  end

endmodule
